>>> rtl/adcilp_pkg.sv
// ----------------------------------------------------------------------------
// adcilp_pkg: shared types and constants
// Transaction payloads, register indexes and fixed widths of the ADC lowpass
// decimator.
// ----------------------------------------------------------------------------
package adcilp_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int VALUE_W    = 16;
   localparam int WEIGHT_W   = 15;
   localparam int FACTOR_W   = 10;
   localparam int LIMIT_W    = 11;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 15;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] REG_SMOOTHING_WEIGHT  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DECIMATION_FACTOR = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_OUTPUT_LIMIT      = 2'd2;

   // register reset values
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 15'd8192;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 10'd10;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 11'd512;

   typedef struct packed {
      logic [SAMPLE_W-1:0] adc_sample;
      logic                frame_start;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] filtered_value;
      logic                      last_of_frame;
   } rsp_payload_type;

   // decimator status towards the top level
   typedef struct packed {
      logic emit;
      logic last;
   } decim_status_type;

endpackage

>>> rtl/adcilp_filter.sv
// ----------------------------------------------------------------------------
// adcilp_filter: one-pole Q15 lowpass
// Centres the raw sample, scales it to Q15 and mixes it with the filter
// memory; the memory takes the new output on every processed transaction.
// ----------------------------------------------------------------------------
module adcilp_filter (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      advance,
   input  logic                                      frame_start,
   input  logic [adcilp_pkg::SAMPLE_W-1:0]           adc_sample,
   input  logic [adcilp_pkg::WEIGHT_W-1:0]           weight,
   output logic signed [adcilp_pkg::VALUE_W-1:0]     filtered
);

   logic signed [15:0] mem_ff;
   logic signed [15:0] mem_in;
   logic signed [15:0] x_q15;
   logic signed [15:0] prev;
   logic signed [15:0] weight_s;
   logic        [16:0] weight_inv;
   logic signed [17:0] weight_inv_s;
   logic signed [31:0] prod_new;
   logic signed [33:0] prod_old;
   logic signed [33:0] acc;
   logic signed [18:0] shifted;

   always_comb begin
      // raw - 2048 is the raw word with its top bit inverted, then << 3
      x_q15        = {~adc_sample[11], ~adc_sample[11], adc_sample[10:0], 3'b000};
      prev         = frame_start ? 16'sd0 : mem_ff;
      weight_s     = signed'({1'b0, weight});
      weight_inv   = 17'd32768 - {2'b00, weight};
      weight_inv_s = signed'({1'b0, weight_inv});
      prod_new     = x_q15 * weight_s;
      prod_old     = prev * weight_inv_s;
      acc          = 34'(prod_new) + prod_old;
      shifted      = acc[33:15];
      if (shifted > 19'sd32767) begin
         filtered = 16'sd32767;
      end else if (shifted < -19'sd32768) begin
         filtered = -16'sd32768;
      end else begin
         filtered = shifted[15:0];
      end
      mem_in = advance ? filtered : mem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_ff <= '0;
      end else begin
         mem_ff <= mem_in;
      end
   end

endmodule

>>> rtl/adcilp_decim.sv
// ----------------------------------------------------------------------------
// adcilp_decim: decimation phase and output count
// Decides whether a processed transaction yields a result and whether that
// result closes the frame.
// ----------------------------------------------------------------------------
module adcilp_decim (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                frame_start,
   input  logic [adcilp_pkg::FACTOR_W-1:0]     factor,
   input  logic [adcilp_pkg::LIMIT_W-1:0]      limit,
   output adcilp_pkg::decim_status_type        status
);

   logic [9:0]  phase_ff;
   logic [9:0]  phase_in;
   logic [10:0] count_ff;
   logic [10:0] count_in;
   logic [9:0]  factor_eff;
   logic [9:0]  phase_cur;
   logic [10:0] count_cur;
   logic [10:0] phase_inc;
   logic [10:0] count_inc;
   logic [9:0]  phase_next;

   always_comb begin
      factor_eff = (factor == '0) ? 10'd1 : factor;
      phase_cur  = frame_start ? '0 : phase_ff;
      count_cur  = frame_start ? '0 : count_ff;
      phase_inc  = {1'b0, phase_cur} + 11'd1;
      count_inc  = count_cur + 11'd1;
      // a phase left above a lowered factor still wraps here
      phase_next = (phase_inc >= {1'b0, factor_eff}) ? '0 : phase_inc[9:0];

      status.emit = (phase_cur == '0) && (count_cur < limit);
      status.last = status.emit && (count_inc == limit);

      phase_in = phase_ff;
      count_in = count_ff;
      if (advance) begin
         phase_in = phase_next;
         count_in = status.emit ? count_inc : count_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/adc_iir_lowpass_decimator_top.sv
// ----------------------------------------------------------------------------
// adc_iir_lowpass_decimator_top: ADC lowpass decimator
// Q15 one-pole lowpass over 12-bit converter samples, keeping the first
// sample of each decimation group up to a per-frame output limit.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload                       dir
//  req       req_valid/req_ready    adcilp_pkg::req_payload_type  in
//  rsp       rsp_valid/rsp_ready    adcilp_pkg::rsp_payload_type  out
//  csr       csr_we (no wait)       csr_addr, csr_wdata           in
//
//  One transaction per cycle while no held result stalls; rsp_valid rises when
//  the result register loads, after the input register loaded at acceptance.
//  The filter memory loop (two multiplies, one add, clamp) is combinational.
//  Reset clears the counters, filter memory, valid flags and loads the
//  register defaults (weight 8192, factor 10, limit 512).
//  A held result only stalls the input register if the next transaction
//  would itself yield a result; transactions that yield none pass freely.
// ----------------------------------------------------------------------------
module adc_iir_lowpass_decimator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  adcilp_pkg::req_payload_type          req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output adcilp_pkg::rsp_payload_type          rsp_data,
   input  logic                                 csr_we,
   input  logic [adcilp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [adcilp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration registers
   logic [adcilp_pkg::WEIGHT_W-1:0] weight_ff;
   logic [adcilp_pkg::WEIGHT_W-1:0] weight_in;
   logic [adcilp_pkg::FACTOR_W-1:0] factor_ff;
   logic [adcilp_pkg::FACTOR_W-1:0] factor_in;
   logic [adcilp_pkg::LIMIT_W-1:0]  limit_ff;
   logic [adcilp_pkg::LIMIT_W-1:0]  limit_in;

   // input register
   logic                            in_valid_ff;
   logic                            in_valid_in;
   adcilp_pkg::req_payload_type     in_data_ff;
   adcilp_pkg::req_payload_type     in_data_in;

   // result register
   logic                            out_valid_ff;
   logic                            out_valid_in;
   adcilp_pkg::rsp_payload_type     out_data_ff;
   adcilp_pkg::rsp_payload_type     out_data_in;

   logic                                     advance;
   logic                                     req_fire;
   logic signed [adcilp_pkg::VALUE_W-1:0]    filtered;
   adcilp_pkg::decim_status_type             status;

   adcilp_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .frame_start (in_data_ff.frame_start),
      .adc_sample  (in_data_ff.adc_sample),
      .weight      (weight_ff),
      .filtered    (filtered)
   );

   adcilp_decim u_decim (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .frame_start (in_data_ff.frame_start),
      .factor      (factor_ff),
      .limit       (limit_ff),
      .status      (status)
   );

   // csr writes, truncated to each register's width
   always_comb begin
      weight_in = weight_ff;
      factor_in = factor_ff;
      limit_in  = limit_ff;
      if (csr_we) begin
         case (csr_addr)
            adcilp_pkg::REG_SMOOTHING_WEIGHT:  weight_in = csr_wdata[14:0];
            adcilp_pkg::REG_DECIMATION_FACTOR: factor_in = csr_wdata[9:0];
            adcilp_pkg::REG_OUTPUT_LIMIT:      limit_in  = csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // the held transaction moves on unless it yields a result and the
   // result register is still occupied
   always_comb begin
      advance   = in_valid_ff && (!status.emit || !out_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || advance;
      req_fire  = req_valid && req_ready;

      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance && status.emit) begin
         out_valid_in               = 1'b1;
         out_data_in.filtered_value = filtered;
         out_data_in.last_of_frame  = status.last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff    <= adcilp_pkg::WEIGHT_RESET;
         factor_ff    <= adcilp_pkg::FACTOR_RESET;
         limit_ff     <= adcilp_pkg::LIMIT_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         weight_ff    <= weight_in;
         factor_ff    <= factor_in;
         limit_ff     <= limit_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTH
   // a transaction waiting in the input register is not overwritten or lost
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("input register changed while stalled");

   // a produced result shows up on the rsp channel next cycle
   a_emit_visible: assert property (@(posedge clock) disable iff (reset)
      advance && status.emit |=> rsp_valid)
      else $error("result lost after emit");

   // a result is never produced over an untaken one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      advance && status.emit |-> !out_valid_ff || rsp_ready)
      else $error("result register overwritten");

   // frame end flag only on a result
   a_last_emit: assert property (@(posedge clock) disable iff (reset)
      status.last |-> status.emit)
      else $error("last flagged without result");
`endif

endmodule

>>> tb/adc_iir_lowpass_decimator_top_tb.sv
// ----------------------------------------------------------------------------
// adc_iir_lowpass_decimator_top_tb: self-checking bench for the ADC decimator
// Drives converter samples over a valid/ready channel with random gaps and
// back-pressure, and runs a cycle-free model of the Q15 lowpass and decimator.
// Each received output transaction is checked against that model in order.
// ----------------------------------------------------------------------------
module adc_iir_lowpass_decimator_top_tb;

   localparam int RUN_LIMIT    = 300000;  // watchdog, in clock cycles
   localparam int SETTLE_TICKS = 8;       // drain time after the last result
   localparam int RAND_PHASES  = 10;
   localparam int PHASE_ITEMS  = 36;

   // ---- clock, reset and block inputs, all known from time zero ----
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   adcilp_pkg::req_payload_type          req_data  = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   adcilp_pkg::rsp_payload_type          rsp_data;
   logic                                 csr_we    = 1'b0;
   logic [adcilp_pkg::CSR_ADDR_W-1:0]    csr_addr  = '0;
   logic [adcilp_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   always #5 clock = ~clock;

   adc_iir_lowpass_decimator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // ---- shadow of the block: register copies and filter/decimator state ----
   int cfg_weight = 8192;
   int cfg_factor = 10;
   int cfg_limit  = 512;

   int filt_mem   = 0;   // last filter output, signed Q15
   int dec_phase  = 0;   // position within the decimation group
   int out_count  = 0;   // outputs emitted in the current frame

   adcilp_pkg::req_payload_type pending_samples[$];   // waiting to be driven
   adcilp_pkg::rsp_payload_type expected_outputs[$];  // predicted, not yet received

   bit quiet_tail  = 1'b0;  // no idling on either side once set
   int mismatches  = 0;
   int req_gap     = 0;
   int rsp_stall   = 0;
   int cycle_count = 0;

   // One accepted sample through the filter and decimator. Pushes the output
   // that it causes, if any.
   function automatic void predict_lowpass_output(adcilp_pkg::req_payload_type item);
      int                          x;
      int                          y;
      int                          factor;
      longint                      acc;
      adcilp_pkg::rsp_payload_type res;
      factor = (cfg_factor == 0) ? 1 : cfg_factor;
      if (item.frame_start) begin
         filt_mem  = 0;
         dec_phase = 0;
         out_count = 0;
      end
      // centre on mid-scale and scale 12 bits up to Q15
      x   = (int'(item.adc_sample) - 2048) * 8;
      acc = longint'(x) * longint'(cfg_weight)
          + longint'(filt_mem) * longint'(32768 - cfg_weight);
      acc = acc >>> 15;  // floor
      if (acc > 32767)       y = 32767;
      else if (acc < -32768) y = -32768;
      else                   y = int'(acc);
      filt_mem = y;
      if (dec_phase == 0 && out_count < cfg_limit) begin
         out_count          = (out_count + 1) & 'h7FF;
         res.filtered_value = y[adcilp_pkg::VALUE_W-1:0];
         res.last_of_frame  = (out_count == cfg_limit);
         expected_outputs.push_back(res);
      end
      dec_phase = dec_phase + 1;
      if (dec_phase >= factor) dec_phase = 0;
      dec_phase = dec_phase & 'h3FF;
   endfunction

   // ---- driver: predicts on acceptance, then presents the next sample ----
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_lowpass_output(req_data);
         // payload may only change once the current transaction is gone
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
               req_gap   <= $urandom_range(0, 18);  // idle burst of random length
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_data  <= pending_samples.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---- sink back-pressure ----
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
         rsp_stall <= $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---- monitor: in-order compare against the oldest prediction ----
   always @(posedge clock) begin
      adcilp_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outputs.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected output: value %0d last %0b",
                        rsp_data.filtered_value, rsp_data.last_of_frame);
            mismatches = mismatches + 1;
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_data.filtered_value !== want.filtered_value ||
                rsp_data.last_of_frame !== want.last_of_frame) begin
               if (mismatches < 10)
                  $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                           want.filtered_value, want.last_of_frame,
                           rsp_data.filtered_value, rsp_data.last_of_frame);
               mismatches = mismatches + 1;
            end
         end
      end
   end

   // ---- watchdog ----
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---- stimulus helpers ----
   function automatic void add_sample(int raw, bit fs);
      adcilp_pkg::req_payload_type item;
      item.adc_sample  = raw[adcilp_pkg::SAMPLE_W-1:0];
      item.frame_start = fs;
      pending_samples.push_back(item);
   endfunction

   // skewed towards the rails and mid-scale
   function automatic int pick_sample();
      case ($urandom_range(0, 11))
         0:       return 0;
         1:       return 4095;
         2:       return 2048;
         3:       return 2047;
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   task automatic write_register(logic [adcilp_pkg::CSR_ADDR_W-1:0] idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[adcilp_pkg::CSR_DATA_W-1:0];
      case (idx)
         adcilp_pkg::REG_SMOOTHING_WEIGHT:  cfg_weight = value & 'h7FFF;
         adcilp_pkg::REG_DECIMATION_FACTOR: cfg_factor = value & 'h3FF;
         adcilp_pkg::REG_OUTPUT_LIMIT:      cfg_limit  = value & 'h7FF;
         default: ;
      endcase
   endtask

   task automatic load_settings(int weight, int factor, int limit);
      write_register(adcilp_pkg::REG_SMOOTHING_WEIGHT, weight);
      write_register(adcilp_pkg::REG_DECIMATION_FACTOR, factor);
      write_register(adcilp_pkg::REG_OUTPUT_LIMIT, limit);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait for every sample to be taken and every output to arrive, then let
   // samples that cause no output leave the pipeline too.
   task automatic drain_and_settle();
      while (pending_samples.size() != 0 || req_valid || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // ---- test sequence ----
   initial begin
      int weight;
      int factor;
      int limit;
      int n;
      int len;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register defaults: rails and mid-scale, stopping at phase 7 of a
      // group of 10.
      add_sample(0, 1'b1);
      add_sample(4095, 1'b0);
      add_sample(4095, 1'b0);
      add_sample(2048, 1'b0);
      add_sample(0, 1'b0);
      add_sample(4095, 1'b0);
      add_sample(1, 1'b0);
      drain_and_settle();

      // Factor lowered below the running phase: phase must wrap, not stall.
      // Full weight, limit at its top value.
      load_settings(32767, 3, 2047);
      @(negedge clock);
      add_sample(4095, 1'b0);
      add_sample(4095, 1'b0);
      add_sample(0, 1'b0);
      add_sample(0, 1'b0);
      drain_and_settle();

      // Zero weight, factor zero taken as one, count reaching a limit of two
      // and then holding.
      load_settings(0, 0, 2);
      @(negedge clock);
      add_sample(4095, 1'b1);
      add_sample(4095, 1'b0);
      add_sample(0, 1'b0);
      add_sample(0, 1'b0);
      drain_and_settle();

      // Limit zero: filter keeps running, nothing comes out.
      load_settings(32767, 1, 0);
      @(negedge clock);
      add_sample(4095, 1'b1);
      add_sample(0, 1'b0);
      add_sample(2048, 1'b0);
      drain_and_settle();

      // Largest factor, limit one: every frame gives one output, flagged last.
      load_settings(20000, 1023, 1);
      @(negedge clock);
      add_sample(100, 1'b1);
      add_sample(4000, 1'b0);
      add_sample(5, 1'b1);
      drain_and_settle();

      // Random phases: mostly framed bursts with small limits and factors so
      // the count runs into its limit; some frames lack the start flag and
      // stray starts land mid-frame.
      for (int p = 0; p < RAND_PHASES; p++) begin
         case ($urandom_range(0, 5))
            0:       weight = 0;
            1:       weight = 32767;
            default: weight = $urandom_range(0, 32767);
         endcase
         case ($urandom_range(0, 9))
            0:          factor = 0;
            1:          factor = 1023;
            2, 3:       factor = $urandom_range(5, 40);
            default:    factor = $urandom_range(1, 4);
         endcase
         case ($urandom_range(0, 9))
            0:       limit = 0;
            1:       limit = 2047;
            2:       limit = 1024;
            3:       limit = $urandom_range(9, 100);
            default: limit = $urandom_range(1, 8);
         endcase
         if (p == RAND_PHASES - 1) quiet_tail = 1'b1;
         load_settings(weight, factor, limit);
         @(negedge clock);
         n = 0;
         while (n < PHASE_ITEMS) begin
            len = $urandom_range(3, 24);
            add_sample(pick_sample(), $urandom_range(0, 7) != 0);
            for (int k = 1; k < len; k++)
               add_sample(pick_sample(), $urandom_range(0, 31) == 0);
            n = n + len;
         end
         drain_and_settle();
      end

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
